### sv/acomp_pkg.sv
// ----------------------------------------------------------------------------
// acomp_pkg
// Shared constants for the alpha over compositing unit: pixel word width and
// the register map of the configuration port.
// ----------------------------------------------------------------------------
package acomp_pkg;

  localparam int PixelBits   = 32;
  localparam int CfgDataBits = 32;
  localparam int CfgAddrBits = 3;

  // register index, taken from paddr[2]
  typedef enum logic {
    REG_TRANSPARENT = 1'b0
  } cfg_reg_t;

endpackage

### sv/acomp_if.sv
// ----------------------------------------------------------------------------
// acomp_in_if / acomp_out_if
// Valid/ready channels carrying a pixel pair in and a composited pixel out.
// ----------------------------------------------------------------------------
interface acomp_in_if;
  logic                           valid;
  logic                           ready;
  logic [acomp_pkg::PixelBits-1:0] dst_pixel;
  logic [acomp_pkg::PixelBits-1:0] src_pixel;

  modport source (output valid, output dst_pixel, output src_pixel, input ready);
  modport sink   (input valid, input dst_pixel, input src_pixel, output ready);
endinterface

interface acomp_out_if;
  logic                           valid;
  logic                           ready;
  logic [acomp_pkg::PixelBits-1:0] result_pixel;

  modport source (output valid, output result_pixel, input ready);
  modport sink   (input valid, input result_pixel, output ready);
endinterface

### sv/alpha_composite_over_unit.sv
// ----------------------------------------------------------------------------
// alpha_composite_over_unit
// Porter-Duff over of two straight-alpha pixels, exact integer math,
// pipelined at one pixel pair per clock while the output is not stalled.
// ----------------------------------------------------------------------------
//   channel  dir  handshake      payload
//   in_if    in   valid/ready    dst_pixel, src_pixel
//   out_if   out  valid/ready    result_pixel
//   cfg_*    in   APB write/read transparent_word at byte address 0
//
// The pipeline is two multiply stages, one restoring divider stage per
// quotient bit, and the output register.
// One pixel pair is taken every cycle while the output is drained.
// rst_n (synchronous) clears all valid bits and the transparent word.
// A stalled output holds; bubbles in the pipeline still close up behind it.
module alpha_composite_over_unit #(
  parameter int CHANNEL_BITS = 8
) (
  input  logic                              clk,
  input  logic                              rst_n,
  acomp_in_if.sink                          in_if,
  acomp_out_if.source                       out_if,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [acomp_pkg::CfgAddrBits-1:0] cfg_paddr,
  input  logic [acomp_pkg::CfgDataBits-1:0] cfg_pwdata,
  output logic [acomp_pkg::CfgDataBits-1:0] cfg_prdata,
  output logic                              cfg_pready
);

  localparam int W = CHANNEL_BITS;

  logic [acomp_pkg::PixelBits-1:0] tw;

  logic           v_w   [W+1];
  logic           rdy_w [W+1];
  logic [3*W-1:0] rem_w [W+1][4];
  logic [W-1:0]   q_w   [W+1][4];
  logic [2*W-1:0] cov_w [W+1];
  logic           z_w   [W+1];
  logic [W-1:0]   alpha_w;

  logic                            out_valid_r;
  logic [acomp_pkg::PixelBits-1:0] result_r, result_nxt;
  logic                            out_en;
  logic [4*W-1:0]                  pack;

  acomp_cfg u_cfg (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (cfg_psel),
    .penable          (cfg_penable),
    .pwrite           (cfg_pwrite),
    .paddr            (cfg_paddr),
    .pwdata           (cfg_pwdata),
    .prdata           (cfg_prdata),
    .pready           (cfg_pready),
    .transparent_word (tw)
  );

  acomp_mul #(.W(W)) u_mul (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .dst_pixel (in_if.dst_pixel),
    .src_pixel (in_if.src_pixel),
    .out_valid (v_w[0]),
    .out_ready (rdy_w[0]),
    .rem       (rem_w[0]),
    .cov       (cov_w[0]),
    .alpha     (alpha_w),
    .zero      (z_w[0])
  );

  // lane 0 enters with the finished alpha, colour lanes start empty
  assign q_w[0] = '{alpha_w, '0, '0, '0};

  // one stage per quotient bit, most significant first
  for (genvar j = 0; j < W; j++) begin : g_div
    acomp_div_step #(.W(W), .STEP(W-1-j)) u_step (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (v_w[j]),
      .in_ready  (rdy_w[j]),
      .rem_i     (rem_w[j]),
      .q_i       (q_w[j]),
      .cov_i     (cov_w[j]),
      .zero_i    (z_w[j]),
      .out_valid (v_w[j+1]),
      .out_ready (rdy_w[j+1]),
      .rem_o     (rem_w[j+1]),
      .q_o       (q_w[j+1]),
      .cov_o     (cov_w[j+1]),
      .zero_o    (z_w[j+1])
    );
  end

  assign out_en   = !out_valid_r || out_if.ready;
  assign rdy_w[W] = out_en;

  always_comb begin
    pack       = {q_w[W][3], q_w[W][2], q_w[W][1], q_w[W][0]};
    result_nxt = z_w[W] ? tw : acomp_pkg::PixelBits'(pack);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_en) begin
      out_valid_r <= v_w[W];
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      result_r <= result_nxt;
    end
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.result_pixel = result_r;

  // input stalls only when the output holds an untaken result
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    !in_if.ready |-> (out_valid_r && !out_if.ready))
    else $error("input stalled without output backpressure");

  // a finished division leaves remainders below their divisors
  a_color_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (v_w[W] && !z_w[W]) |-> (rem_w[W][1] < (3*W)'(cov_w[W])
                          && rem_w[W][2] < (3*W)'(cov_w[W])
                          && rem_w[W][3] < (3*W)'(cov_w[W])))
    else $error("colour division left remainder too large");

  // zero coverage means both alphas were zero
  a_zero_cov: assert property (@(posedge clk) disable iff (!rst_n)
    v_w[W] |-> (z_w[W] == (cov_w[W] == '0)))
    else $error("zero flag disagrees with coverage");

endmodule

### sv/acomp_cfg.sv
// ----------------------------------------------------------------------------
// acomp_cfg
// APB register block holding the word returned for fully transparent output.
// ----------------------------------------------------------------------------
module acomp_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [acomp_pkg::CfgAddrBits-1:0] paddr,
  input  logic [acomp_pkg::CfgDataBits-1:0] pwdata,
  output logic [acomp_pkg::CfgDataBits-1:0] prdata,
  output logic                              pready,
  output logic [acomp_pkg::PixelBits-1:0]   transparent_word
);

  logic [acomp_pkg::PixelBits-1:0] tw_r;
  logic [acomp_pkg::PixelBits-1:0] tw_nxt;
  logic                            hit;

  assign hit    = (paddr[2] == acomp_pkg::REG_TRANSPARENT);
  assign pready = 1'b1;

  always_comb begin
    tw_nxt = tw_r;
    if (psel && penable && pwrite && hit) begin
      tw_nxt = pwdata[acomp_pkg::PixelBits-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tw_r <= '0;
    end else begin
      tw_r <= tw_nxt;
    end
  end

  assign prdata           = hit ? tw_r : '0;
  assign transparent_word = tw_r;

endmodule

### sv/acomp_mul.sv
// ----------------------------------------------------------------------------
// acomp_mul
// Two multiply stages: channel products and combined coverage, then the
// per-channel numerators that feed the divider and the output alpha.
// ----------------------------------------------------------------------------
module acomp_mul #(
  parameter int W = 8
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [acomp_pkg::PixelBits-1:0] dst_pixel,
  input  logic [acomp_pkg::PixelBits-1:0] src_pixel,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [3*W-1:0]                  rem [4],
  output logic [2*W-1:0]                  cov,
  output logic [W-1:0]                    alpha,
  output logic                            zero
);

  localparam logic [W-1:0] MaxCh = '1;

  logic [4*W-1:0] dw, sw;
  logic [W-1:0]   sa, da, ma_nxt;
  logic [2*W-1:0] dm;

  // stage 1
  logic           v1_r;
  logic [2*W-1:0] ps_r [3];
  logic [2*W-1:0] ps_nxt [3];
  logic [2*W-1:0] pd_r [3];
  logic [2*W-1:0] pd_nxt [3];
  logic [W-1:0]   ma_r;
  logic [2*W-1:0] cov1_r, cov1_nxt;
  logic           z1_r, z1_nxt;
  logic           en1, en2;

  // stage 2
  logic           v2_r;
  logic [3*W-1:0] rem_r [4];
  logic [3*W-1:0] rem_nxt [4];
  logic [2*W-1:0] cov2_r;
  logic           z2_r;
  logic [2*W-1:0] asum;
  logic [W-1:0]   alpha_nxt;
  logic [W-1:0]   alpha_r;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_comb begin
    dw       = (4*W)'(dst_pixel);
    sw       = (4*W)'(src_pixel);
    sa       = sw[W-1:0];
    da       = dw[W-1:0];
    ma_nxt   = MaxCh - sa;
    dm       = da * ma_nxt;
    cov1_nxt = ((2*W)'(sa) << W) - (2*W)'(sa) + dm;
    z1_nxt   = (sa == '0) && (da == '0);
    for (int k = 0; k < 3; k++) begin
      ps_nxt[k] = sw[(k+1)*W +: W] * sa;
      pd_nxt[k] = dw[(k+1)*W +: W] * da;
    end
  end

  always_comb begin
    // divide by the channel maximum: floor(x/M) = (x + (x >> W) + 1) >> W for x <= M*M
    asum       = cov1_r + (cov1_r >> W) + (2*W)'(1);
    alpha_nxt  = asum[2*W-1:W];
    rem_nxt[0] = '0;
    for (int k = 0; k < 3; k++) begin
      rem_nxt[k+1] = ((3*W)'(ps_r[k]) << W) - (3*W)'(ps_r[k])
                   + (3*W)'(pd_r[k]) * (3*W)'(ma_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      ps_r   <= ps_nxt;
      pd_r   <= pd_nxt;
      ma_r   <= ma_nxt;
      cov1_r <= cov1_nxt;
      z1_r   <= z1_nxt;
    end
    if (en2) begin
      rem_r   <= rem_nxt;
      cov2_r  <= cov1_r;
      z2_r    <= z1_r;
      alpha_r <= alpha_nxt;
    end
  end

  assign out_valid = v2_r;
  assign rem       = rem_r;
  assign cov       = cov2_r;
  assign alpha     = alpha_r;
  assign zero      = z2_r;

endmodule

### sv/acomp_div_step.sv
// ----------------------------------------------------------------------------
// acomp_div_step
// One restoring division step: lanes 1..3 divide the colour numerators by
// the coverage, lane 0 carries the alpha quotient through unchanged.
// ----------------------------------------------------------------------------
module acomp_div_step #(
  parameter int W    = 8,
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic [3*W-1:0] rem_i [4],
  input  logic [W-1:0]   q_i [4],
  input  logic [2*W-1:0] cov_i,
  input  logic           zero_i,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [3*W-1:0] rem_o [4],
  output logic [W-1:0]   q_o [4],
  output logic [2*W-1:0] cov_o,
  output logic           zero_o
);

  logic           v_r;
  logic           en;
  logic [3*W-1:0] rem_r [4];
  logic [3*W-1:0] rem_nxt [4];
  logic [W-1:0]   q_r [4];
  logic [W-1:0]   q_nxt [4];
  logic [2*W-1:0] cov_r;
  logic           zero_r;
  logic [3*W-1:0] dvs;

  assign en       = !v_r || out_ready;
  assign in_ready = en;

  always_comb begin
    dvs = (3*W)'(cov_i) << STEP;
    for (int k = 0; k < 4; k++) begin
      rem_nxt[k] = rem_i[k];
      q_nxt[k]   = q_i[k];
    end
    for (int k = 1; k < 4; k++) begin
      if (rem_i[k] >= dvs) begin
        rem_nxt[k]     = rem_i[k] - dvs;
        q_nxt[k][STEP] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (en) begin
      v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      q_r    <= q_nxt;
      cov_r  <= cov_i;
      zero_r <= zero_i;
    end
  end

  assign out_valid = v_r;
  assign rem_o     = rem_r;
  assign q_o       = q_r;
  assign cov_o     = cov_r;
  assign zero_o    = zero_r;

endmodule
